// ===== rtl/sflp_pkg.sv =====
// shared types and constants of the sync/length/xor frame parser
package sflp_pkg;

  localparam int SYNC_MAX_BYTES = 4;
  localparam int SYNC_CAP_INT   = (SYNC_MAX_BYTES > 4) ? 4 : SYNC_MAX_BYTES;
  localparam logic [2:0] SYNC_CAP = 3'(SYNC_CAP_INT);

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_PATTERN = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_LENGTH  = CFG_INDEX_W'(1);

  typedef enum logic [2:0] {
    PH_SYNC = 3'd0,
    PH_HLEN = 3'd1,
    PH_PLEN = 3'd2,
    PH_HDR  = 3'd3,
    PH_PAY  = 3'd4,
    PH_CHK  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_GOOD    = 2'd2,
    KIND_BAD     = 2'd3
  } kind_t;

endpackage

// ===== rtl/sflp_ifs.sv =====
// valid/ready channel interfaces for received bytes, results and configuration
interface sflp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sflp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  result_byte;
  logic [7:0]  frame_header_len;
  logic [31:0] frame_payload_len;
  logic [7:0]  calc_checksum;
  modport source (output valid, output result_kind, output result_byte,
                  output frame_header_len, output frame_payload_len,
                  output calc_checksum, input ready);
  modport sink (input valid, input result_kind, input result_byte,
                input frame_header_len, input frame_payload_len,
                input calc_checksum, output ready);
endinterface

interface sflp_cfg_if;
  import sflp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sync_length_xor_frame_parser.sv =====
// sync hunt, length decode and xor check deframer, top level
//
//  channel | dir | payload                                        | beat when
//  cfg     | in  | index, data                                    | valid && ready
//  rx      | in  | rx_byte                                        | valid && ready
//  res     | out | result_kind, result_byte, frame_header_len,    | valid && ready
//          |     | frame_payload_len, calc_checksum               |
//
//  one byte per cycle sustained while res takes results; a byte is held in the input
//  register and its result then passes to the result register
//  the input register is a one-beat skid: rx takes one more byte while a result waits
//  bytes that give no result (sync, lengths) pass even while res is stalled
//  rst is synchronous: hunt restarts, sync_length returns to 2, sync_pattern to 0
//  cfg is always ready and its writes take effect at once
module sync_length_xor_frame_parser (
  input  logic        clk,
  input  logic        rst,
  sflp_cfg_if.sink    cfg,
  sflp_rx_if.sink     rx,
  sflp_res_if.source  res
);
  import sflp_pkg::*;

  logic [31:0] sync_pattern;
  logic [2:0]  sync_length;

  logic        in_valid;
  logic [7:0]  in_byte;

  phase_t      phase, phase_next;
  logic [1:0]  sync_index, sync_index_next;
  logic [31:0] field_count, field_count_next;
  logic [7:0]  header_len, header_len_next;
  logic [31:0] payload_len, payload_len_next;
  logic [7:0]  running_xor, running_xor_next;

  logic        out_valid;
  kind_t       out_kind;
  logic [7:0]  out_byte;
  logic [7:0]  out_hlen;
  logic [31:0] out_plen;
  logic [7:0]  out_chk;

  logic [2:0]  eff_len;
  logic [1:0]  idx;
  logic [2:0]  idx_inc;
  logic [1:0]  byte_sel;
  logic [7:0]  want;
  logic [7:0]  xor_b;
  logic [31:0] count_inc;
  logic [31:0] plen_shift;
  logic        emit;
  kind_t       emit_kind;
  logic [7:0]  emit_chk;
  logic        advance;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern <= '0;
      sync_length  <= 3'd2;
    end else if (cfg.valid) begin
      if (cfg.index == REG_SYNC_PATTERN) begin
        sync_pattern <= cfg.data;
      end else if (cfg.index == REG_SYNC_LENGTH) begin
        sync_length <= cfg.data[2:0];
      end
    end
  end

  always_comb begin
    if (sync_length == 3'd0) begin
      eff_len = 3'd1;
    end else if (sync_length > SYNC_CAP) begin
      eff_len = SYNC_CAP;
    end else begin
      eff_len = sync_length;
    end
  end

  // input register
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  // per-byte decode
  always_comb begin
    idx        = ({1'b0, sync_index} >= eff_len) ? 2'd0 : sync_index;
    idx_inc    = {1'b0, idx} + 3'd1;
    byte_sel   = 2'(eff_len - 3'd1 - {1'b0, idx});
    want       = sync_pattern[{byte_sel, 3'b000} +: 8];
    xor_b      = running_xor ^ in_byte;
    count_inc  = field_count + 32'd1;
    plen_shift = {payload_len[23:0], in_byte};

    phase_next       = phase;
    sync_index_next  = sync_index;
    field_count_next = field_count;
    header_len_next  = header_len;
    payload_len_next = payload_len;
    running_xor_next = running_xor;
    emit             = 1'b0;
    emit_kind        = KIND_HEADER;
    emit_chk         = xor_b;

    case (phase)
      PH_SYNC: begin
        if (in_byte == want) begin
          running_xor_next = xor_b;
          if (idx_inc >= eff_len) begin
            sync_index_next  = 2'd0;
            field_count_next = '0;
            phase_next       = PH_HLEN;
          end else begin
            sync_index_next = idx_inc[1:0];
          end
        end else begin
          sync_index_next  = 2'd0;
          field_count_next = '0;
          running_xor_next = '0;
        end
      end
      PH_HLEN: begin
        running_xor_next = xor_b;
        header_len_next  = in_byte;
        payload_len_next = '0;
        field_count_next = '0;
        phase_next       = PH_PLEN;
      end
      PH_PLEN: begin
        running_xor_next = xor_b;
        payload_len_next = plen_shift;
        field_count_next = count_inc;
        if (count_inc >= 32'd4) begin
          field_count_next = '0;
          if (header_len != 8'd0) begin
            phase_next = PH_HDR;
          end else if (plen_shift != 32'd0) begin
            phase_next = PH_PAY;
          end else begin
            phase_next = PH_CHK;
          end
        end
      end
      PH_HDR: begin
        running_xor_next = xor_b;
        emit             = 1'b1;
        emit_kind        = KIND_HEADER;
        field_count_next = count_inc;
        if (count_inc >= {24'd0, header_len}) begin
          field_count_next = '0;
          phase_next       = (payload_len != 32'd0) ? PH_PAY : PH_CHK;
        end
      end
      PH_PAY: begin
        running_xor_next = xor_b;
        emit             = 1'b1;
        emit_kind        = KIND_PAYLOAD;
        field_count_next = count_inc;
        if (count_inc >= payload_len) begin
          field_count_next = '0;
          phase_next       = PH_CHK;
        end
      end
      PH_CHK: begin
        emit             = 1'b1;
        emit_kind        = (in_byte == running_xor) ? KIND_GOOD : KIND_BAD;
        emit_chk         = running_xor;
        phase_next       = PH_SYNC;
        sync_index_next  = 2'd0;
        field_count_next = '0;
        running_xor_next = '0;
      end
      default: begin
        phase_next       = PH_SYNC;
        sync_index_next  = 2'd0;
        field_count_next = '0;
        running_xor_next = '0;
      end
    endcase
  end

  assign advance = in_valid && (!emit || !out_valid || res.ready);

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SYNC;
      sync_index  <= 2'd0;
      field_count <= '0;
      header_len  <= '0;
      payload_len <= '0;
      running_xor <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      sync_index  <= sync_index_next;
      field_count <= field_count_next;
      header_len  <= header_len_next;
      payload_len <= payload_len_next;
      running_xor <= running_xor_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_kind <= emit_kind;
      out_byte <= in_byte;
      out_hlen <= header_len;
      out_plen <= payload_len;
      out_chk  <= emit_chk;
    end
  end

  assign res.valid             = out_valid;
  assign res.result_kind       = out_kind;
  assign res.result_byte       = out_byte;
  assign res.frame_header_len  = out_hlen;
  assign res.frame_payload_len = out_plen;
  assign res.calc_checksum     = out_chk;

endmodule

// ===== rtl/sflp_checker.sv =====
// port-level checks of the frame parser and their binding
module sflp_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  res_kind,
  input logic [7:0]  res_byte,
  input logic [7:0]  res_hlen,
  input logic [31:0] res_plen,
  input logic [7:0]  res_chk
);
  import sflp_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_byte)
      && $stable(res_chk))
    else $error("stalled result changed");

  // status kind agrees with the checksum compare
  a_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_kind == KIND_GOOD || res_kind == KIND_BAD)
      |-> ((res_kind == KIND_GOOD) == (res_byte == res_chk)))
    else $error("status kind does not match checksum compare");

  // header bytes only come out of frames with a header
  a_hdr_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_HEADER |-> res_hlen != 8'd0)
    else $error("header byte with zero header length");

  // payload bytes only come out of frames with a payload
  a_pay_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_PAYLOAD |-> res_plen != 32'd0)
    else $error("payload byte with zero payload length");

  // nothing is offered straight after reset
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind sync_length_xor_frame_parser sflp_checker u_sflp_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_kind  (res.result_kind),
  .res_byte  (res.result_byte),
  .res_hlen  (res.frame_header_len),
  .res_plen  (res.frame_payload_len),
  .res_chk   (res.calc_checksum)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the sync/length/xor frame parser: directed frames, then random traffic
module testbench;
  import sflp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 1950;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  hlen;
    logic [31:0] plen;
    logic [7:0]  chk;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst;

  sflp_cfg_if cfg_ch ();
  sflp_rx_if  rx_ch ();
  sflp_res_if res_ch ();

  sync_length_xor_frame_parser dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .rx  (rx_ch),
    .res (res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the deframer
  logic [31:0]   fp_pattern  = 32'h0;
  logic [2:0]    fp_sync_len = 3'd2;
  phase_t        fp_phase    = PH_SYNC;
  logic [1:0]    fp_sync_pos = 2'd0;
  logic [31:0]   fp_count    = 32'h0;
  logic [7:0]    fp_hlen     = 8'h0;
  logic [31:0]   fp_plen     = 32'h0;
  logic [7:0]    fp_xor      = 8'h0;

  frame_result_t pending_results[$];

  int  mismatches = 0;
  int  cycles     = 0;
  int  rx_beats   = 0;
  int  res_beats  = 0;
  int  reg_writes = 0;
  int  frames     = 0;
  int  bytes_sent = 0;
  bit  idle_on    = 1'b1;
  bit  hold_req   = 1'b0;

  function automatic logic [2:0] eff_sync_len();
    logic [2:0] n;
    n = fp_sync_len;
    if (n == 3'd0) n = 3'd1;
    if (n > SYNC_CAP) n = SYNC_CAP;
    return n;
  endfunction

  function automatic void restart_hunt();
    fp_phase    = PH_SYNC;
    fp_sync_pos = 2'd0;
    fp_count    = 32'h0;
    fp_xor      = 8'h0;
  endfunction

  function automatic void queue_result(input kind_t k, input logic [7:0] d);
    frame_result_t r;
    r.kind = k;
    r.data = d;
    r.hlen = fp_hlen;
    r.plen = fp_plen;
    r.chk  = fp_xor;
    pending_results.push_back(r);
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    int         ni;
    int         ii;
    logic [7:0] want;
    case (fp_phase)
      PH_SYNC: begin
        ni = eff_sync_len();
        ii = fp_sync_pos;
        if (ii >= ni) ii = 0;
        want = fp_pattern[8*(ni-1-ii) +: 8];
        if (b == want) begin
          fp_xor ^= b;
          ii++;
          if (ii >= ni) begin
            fp_sync_pos = 2'd0;
            fp_count    = 32'h0;
            fp_phase    = PH_HLEN;
          end else begin
            fp_sync_pos = 2'(ii);
          end
        end else begin
          restart_hunt();
        end
      end
      PH_HLEN: begin
        fp_xor  ^= b;
        fp_hlen  = b;
        fp_plen  = 32'h0;
        fp_count = 32'h0;
        fp_phase = PH_PLEN;
      end
      PH_PLEN: begin
        fp_xor  ^= b;
        fp_plen  = {fp_plen[23:0], b};
        fp_count++;
        if (fp_count >= 4) begin
          fp_count = 32'h0;
          if (fp_hlen != 8'h0) fp_phase = PH_HDR;
          else if (fp_plen != 32'h0) fp_phase = PH_PAY;
          else fp_phase = PH_CHK;
        end
      end
      PH_HDR: begin
        fp_xor ^= b;
        queue_result(KIND_HEADER, b);
        fp_count++;
        if (fp_count >= fp_hlen) begin
          fp_count = 32'h0;
          fp_phase = (fp_plen != 32'h0) ? PH_PAY : PH_CHK;
        end
      end
      PH_PAY: begin
        fp_xor ^= b;
        queue_result(KIND_PAYLOAD, b);
        fp_count++;
        if (fp_count >= fp_plen) begin
          fp_count = 32'h0;
          fp_phase = PH_CHK;
        end
      end
      PH_CHK: begin
        queue_result((b == fp_xor) ? KIND_GOOD : KIND_BAD, b);
        restart_hunt();
      end
      default: restart_hunt();
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 20) $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // register writes and accepted bytes feed the shadow
  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      reg_writes++;
      case (cfg_ch.index)
        REG_SYNC_PATTERN: fp_pattern  = cfg_ch.data;
        REG_SYNC_LENGTH:  fp_sync_len = cfg_ch.data[2:0];
        default: ;
      endcase
    end
    if (!rst && rx_ch.valid && rx_ch.ready) begin
      rx_beats++;
      deframe_byte(rx_ch.rx_byte);
    end
  end

  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      res_beats++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result kind %0d byte %h with nothing expected",
                                  res_ch.result_kind, res_ch.result_byte));
      end else begin
        want = pending_results.pop_front();
        if (res_ch.result_kind !== want.kind || res_ch.result_byte !== want.data ||
            res_ch.frame_header_len !== want.hlen ||
            res_ch.frame_payload_len !== want.plen ||
            res_ch.calc_checksum !== want.chk) begin
          report_mismatch($sformatf(
            "got kind %0d byte %h hlen %0d plen %0d chk %h, want %0d %h %0d %0d %h",
            res_ch.result_kind, res_ch.result_byte, res_ch.frame_header_len,
            res_ch.frame_payload_len, res_ch.calc_checksum,
            want.kind, want.data, want.hlen, want.plen, want.chk));
        end
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int gap;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  task automatic wait_drain();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame(input int hlen, input int plen, input bit bad);
    int         n;
    logic [7:0] b;
    logic [7:0] sum;
    n   = eff_sync_len();
    sum = 8'h0;
    for (int i = n - 1; i >= 0; i--) begin
      b = fp_pattern[8*i +: 8];
      sum ^= b;
      send_byte(b);
    end
    b = 8'(hlen);
    sum ^= b;
    send_byte(b);
    for (int i = 3; i >= 0; i--) begin
      b = 8'(plen >> (8 * i));
      sum ^= b;
      send_byte(b);
    end
    repeat (hlen + plen) begin
      b = 8'($urandom);
      sum ^= b;
      send_byte(b);
    end
    if (bad) sum ^= 8'($urandom_range(1, 255));
    send_byte(sum);
    frames++;
  endtask

  // bytes that never start a sync sequence
  task automatic send_noise(input int count);
    logic [7:0] first;
    logic [7:0] b;
    first = fp_pattern[8*(eff_sync_len()-1) +: 8];
    repeat (count) begin
      b = 8'($urandom);
      if (b == first) b ^= 8'h01;
      send_byte(b);
    end
  endtask

  // a sync prefix cut short by a wrong byte
  task automatic send_broken_sync();
    int         n;
    int         k;
    logic [7:0] b;
    n = eff_sync_len();
    if (n == 1) begin
      send_noise(1);
    end else begin
      k = $urandom_range(1, n - 1);
      for (int i = 0; i < k; i++) send_byte(fp_pattern[8*(n-1-i) +: 8]);
      b = 8'($urandom);
      if (b == fp_pattern[8*(n-1-k) +: 8]) b ^= 8'h80;
      send_byte(b);
    end
  endtask

  task automatic test_reset_defaults();
    send_frame(0, 0, 1'b0);
  endtask

  task automatic test_short_sync_extremes();
    wait_drain();
    cfg_write(REG_SYNC_PATTERN, 32'hFFFF_FFFF);
    cfg_write(REG_SYNC_LENGTH, 32'd0);
    send_frame(1, 1, 1'b1);
  endtask

  task automatic test_sync_no_retry();
    wait_drain();
    cfg_write(REG_SYNC_PATTERN, 32'h0000_A55A);
    cfg_write(REG_SYNC_LENGTH, 32'd2);
    send_byte(8'hA5);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_frame(0, 0, 1'b0);
  endtask

  task automatic test_length_change_mid_hunt();
    wait_drain();
    cfg_write(REG_SYNC_PATTERN, 32'h1122_3344);
    cfg_write(REG_SYNC_LENGTH, 32'd7);
    send_byte(8'h11);
    wait_drain();
    cfg_write(REG_SYNC_LENGTH, 32'd1);
    send_frame(0, 0, 1'b0);
  endtask

  task automatic test_backpressure();
    wait_drain();
    cfg_write(REG_SYNC_LENGTH, 32'd4);
    idle_on  = 1'b0;
    hold_req = 1'b1;
    send_frame(3, 60, 1'b0);
    wait_drain();
    idle_on = 1'b1;
  endtask

  task automatic reprogram();
    logic [31:0] pat;
    logic [2:0]  len;
    wait_drain();
    case ($urandom_range(0, 7))
      0:       pat = 32'h0;
      1:       pat = 32'hFFFF_FFFF;
      default: pat = $urandom;
    endcase
    len = 3'($urandom_range(0, 7));
    cfg_write(REG_SYNC_PATTERN, pat);
    cfg_write(REG_SYNC_LENGTH, {29'($urandom), len});
    idle_on = ($urandom_range(0, 3) != 0);
  endtask

  task automatic test_random_traffic();
    int start;
    int hlen;
    int plen;
    int pick;
    bit long_header_done;
    start            = bytes_sent;
    long_header_done = 1'b0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (frames % 6 == 0) reprogram();
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        hlen = $urandom_range(0, 6);
        if (!long_header_done || $urandom_range(0, 199) == 0) begin
          hlen             = 255;
          long_header_done = 1'b1;
        end
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 12);
        send_frame(hlen, plen, $urandom_range(0, 3) == 0);
      end else if (pick < 86) begin
        send_noise($urandom_range(1, 5));
      end else begin
        send_broken_sync();
      end
    end
  endtask

  initial begin
    rst          <= 1'b1;
    rx_ch.valid  <= 1'b0;
    rx_ch.rx_byte <= 8'h0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_short_sync_extremes();
    test_sync_no_retry();
    test_length_change_mid_hunt();
    test_backpressure();
    test_random_traffic();
    wait_drain();

    $display("covered %0d frames, %0d received bytes, %0d results checked", frames, rx_beats,
             res_beats);
    $display("%0d register writes across sync lengths 0..7, %0d mismatches", reg_writes,
             mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
